@@ sv/bdr_pkg.sv @@
`timescale 1ns / 1ps
// shared types, constants and dither helpers for the bayer dither block
package bdr_pkg;

  localparam int DIM_BITS = 10;
  localparam int DIM_MAX  = 1 << DIM_BITS;
  localparam int REG_W    = 11;
  localparam int ADDR_W   = 20;
  localparam int CHAN_W   = 8;
  localparam int PIX_W    = 16;
  localparam int APB_DW   = 32;
  localparam int PADDR_W  = 3;
  localparam int CMP_W    = (DIM_BITS + 1 > REG_W) ? DIM_BITS + 1 : REG_W;
  localparam int PROD_W   = (2 * DIM_BITS + 1 > ADDR_W) ? 2 * DIM_BITS + 1 : ADDR_W;

  localparam logic [REG_W-1:0] WIDTH_RESET  = REG_W'(320);
  localparam logic [REG_W-1:0] HEIGHT_RESET = REG_W'(240);

  typedef logic [DIM_BITS-1:0] cnt_t;
  typedef logic [DIM_BITS:0]   dim_t;
  typedef logic [CHAN_W-1:0]   chan_t;

  typedef enum logic [0:0] {
    CFG_IMAGE_WIDTH  = 1'b0,
    CFG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_t;

  // effective frame size seen by the datapath
  typedef struct packed {
    dim_t width;
    dim_t height;
  } cfg_t;

  // word held in the input register
  typedef struct packed {
    chan_t red;
    chan_t green;
    chan_t blue;
    cnt_t  col;
    cnt_t  row;
    logic  frame_end;
  } pos_word_t;

  localparam logic [3:0] BAYER [4][4] = '{
    '{4'd0,  4'd8,  4'd2,  4'd10},
    '{4'd12, 4'd4,  4'd14, 4'd6},
    '{4'd3,  4'd11, 4'd1,  4'd9},
    '{4'd15, 4'd7,  4'd13, 4'd5}
  };

  // zero acts as one, anything above the counter range saturates
  function automatic dim_t eff_dim(logic [REG_W-1:0] raw);
    logic [CMP_W-1:0] wide;
    wide = CMP_W'(raw);
    if (raw == '0) begin
      return dim_t'(1);
    end else if (wide > CMP_W'(DIM_MAX)) begin
      return dim_t'(DIM_MAX);
    end else begin
      return wide[DIM_BITS:0];
    end
  endfunction

  // t/2 - 4, range -4..3
  function automatic logic signed [3:0] rb_offset(logic [3:0] t);
    return $signed({1'b0, t[3:1]} - 4'd4);
  endfunction

  // t/4 - 2, range -2..1
  function automatic logic signed [3:0] g_offset(logic [3:0] t);
    return $signed({2'b00, t[3:2]} - 4'd2);
  endfunction

  function automatic chan_t dither_chan(chan_t c, logic signed [3:0] off);
    logic signed [9:0] s;
    s = $signed({2'b00, c}) + $signed({{6{off[3]}}, off});
    if (s[9]) begin
      return '0;
    end else if (s[8]) begin
      return '1;
    end else begin
      return s[7:0];
    end
  endfunction

endpackage

@@ sv/bdr_stream_if.sv @@
`timescale 1ns / 1ps
// pixel stream interfaces for the input and result channels
interface bdr_in_if;
  logic                  valid;
  logic                  ready;
  logic [bdr_pkg::CHAN_W-1:0] red;
  logic [bdr_pkg::CHAN_W-1:0] green;
  logic [bdr_pkg::CHAN_W-1:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface bdr_out_if;
  logic                       valid;
  logic                       ready;
  logic [bdr_pkg::PIX_W-1:0]  pixel_565;
  logic [bdr_pkg::ADDR_W-1:0] store_address;
  logic                       frame_end;

  modport source (output valid, output pixel_565, output store_address, output frame_end,
                  input ready);
  modport sink   (input valid, input pixel_565, input store_address, input frame_end,
                  output ready);
endinterface

@@ sv/bdr_cfg_regs.sv @@
`timescale 1ns / 1ps
// apb register file holding frame width and height
module bdr_cfg_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bdr_pkg::PADDR_W-1:0] paddr,
  input  logic [bdr_pkg::APB_DW-1:0]  pwdata,
  output logic [bdr_pkg::APB_DW-1:0]  prdata,
  output logic                        pready,
  output bdr_pkg::cfg_t               cfg
);
  import bdr_pkg::*;

  logic [REG_W-1:0] image_width;
  logic [REG_W-1:0] image_height;
  cfg_reg_t         sel;
  logic             wr_en;

  assign sel    = cfg_reg_t'(paddr[2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WIDTH_RESET;
      image_height <= HEIGHT_RESET;
    end else if (wr_en) begin
      unique case (sel)
        CFG_IMAGE_WIDTH:  image_width  <= pwdata[REG_W-1:0];
        CFG_IMAGE_HEIGHT: image_height <= pwdata[REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (sel)
      CFG_IMAGE_WIDTH:  prdata = APB_DW'(image_width);
      CFG_IMAGE_HEIGHT: prdata = APB_DW'(image_height);
      default:          prdata = '0;
    endcase
  end

  assign cfg.width  = eff_dim(image_width);
  assign cfg.height = eff_dim(image_height);

endmodule

@@ sv/bdr_position.sv @@
`timescale 1ns / 1ps
// raster position counters and input register
module bdr_position (
  input  logic               clk,
  input  logic               rst,
  input  bdr_pkg::cfg_t      cfg,
  bdr_in_if.sink             pix_in,
  output bdr_pkg::pos_word_t word,
  output logic               word_valid,
  input  logic               word_ready
);
  import bdr_pkg::*;

  cnt_t col;
  cnt_t row;
  cnt_t col_next;
  cnt_t row_next;
  dim_t col_plus;
  dim_t row_plus;
  logic last_col;
  logic last_row;
  logic accept;

  assign pix_in.ready = !word_valid || word_ready;
  assign accept       = pix_in.valid && pix_in.ready;

  // a counter past a shrunk limit counts as sitting on the last position
  assign col_plus = dim_t'(col) + dim_t'(1);
  assign row_plus = dim_t'(row) + dim_t'(1);
  assign last_col = col_plus >= cfg.width;
  assign last_row = row_plus >= cfg.height;

  always_comb begin
    col_next = col;
    row_next = row;
    if (last_col) begin
      col_next = '0;
      row_next = last_row ? '0 : row_plus[DIM_BITS-1:0];
    end else begin
      col_next = col_plus[DIM_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col        <= '0;
      row        <= '0;
      word_valid <= 1'b0;
    end else if (accept) begin
      col        <= col_next;
      row        <= row_next;
      word_valid <= 1'b1;
    end else if (word_ready) begin
      word_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      word.red       <= pix_in.red;
      word.green     <= pix_in.green;
      word.blue      <= pix_in.blue;
      word.col       <= col;
      word.row       <= row;
      word.frame_end <= last_col && last_row;
    end
  end

  a_col_step: assert property (@(posedge clk) disable iff (rst)
    accept && !last_col |=> col == $past(col_plus[DIM_BITS-1:0]) && row == $past(row))
    else $error("column counter did not advance");

  a_col_wrap: assert property (@(posedge clk) disable iff (rst)
    accept && last_col |=> col == '0)
    else $error("column counter did not wrap at row end");

  a_frame_wrap: assert property (@(posedge clk) disable iff (rst)
    accept && last_col && last_row |=> row == '0 && word.frame_end)
    else $error("frame end not flagged or row not cleared");

  a_word_hold: assert property (@(posedge clk) disable iff (rst)
    word_valid && !word_ready |=> word_valid && $stable(word))
    else $error("stalled input word changed");

endmodule

@@ sv/bdr_convert.sv @@
`timescale 1ns / 1ps
// ordered dither, rgb565 packing, rotated address and result register
module bdr_convert (
  input  logic               clk,
  input  logic               rst,
  input  bdr_pkg::cfg_t      cfg,
  input  bdr_pkg::pos_word_t word,
  input  logic               word_valid,
  output logic               word_ready,
  bdr_out_if.source          pix_out
);
  import bdr_pkg::*;

  logic [3:0]        t;
  logic signed [3:0] rb_off;
  logic signed [3:0] g_off;
  chan_t             r_d;
  chan_t             g_d;
  chan_t             b_d;
  logic [PROD_W-1:0] prod;
  logic [PROD_W-1:0] flip_row;
  logic [PROD_W-1:0] addr_full;

  assign word_ready = !pix_out.valid || pix_out.ready;

  assign t      = BAYER[word.row[1:0]][word.col[1:0]];
  assign rb_off = rb_offset(t);
  assign g_off  = g_offset(t);
  assign r_d    = dither_chan(word.red, rb_off);
  assign g_d    = dither_chan(word.green, g_off);
  assign b_d    = dither_chan(word.blue, rb_off);

  // column-major address, wraps modulo the address width
  assign prod      = PROD_W'(word.col) * PROD_W'(cfg.height);
  assign flip_row  = PROD_W'(cfg.height) - PROD_W'(1) - PROD_W'(word.row);
  assign addr_full = prod + flip_row;

  always_ff @(posedge clk) begin
    if (rst) begin
      pix_out.valid <= 1'b0;
    end else if (word_ready) begin
      pix_out.valid <= word_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (word_valid && word_ready) begin
      pix_out.pixel_565     <= {r_d[7:3], g_d[7:2], b_d[7:3]};
      pix_out.store_address <= addr_full[ADDR_W-1:0];
      pix_out.frame_end     <= word.frame_end;
    end
  end

  a_load: assert property (@(posedge clk) disable iff (rst)
    word_valid && word_ready |=> pix_out.valid)
    else $error("result register missed a word");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    pix_out.valid && !pix_out.ready |=> pix_out.valid && $stable(pix_out.store_address))
    else $error("stalled result changed");

  a_idle: assert property (@(posedge clk) disable iff (rst)
    !word_valid && word_ready |=> !pix_out.valid)
    else $error("result shown without a word");

endmodule

@@ sv/bayer_dither_rgb565_rotate_top.sv @@
`timescale 1ns / 1ps
// an accepted pixel moves from the input register into the result register
// throughput: one pixel per cycle, sustained while the result side keeps ready high
// both stages hold under backpressure; input ready follows the input register's room
// the multiply for the rotated address sits in the single stage after the input register
// reset clears counters and valid flags, and sets the frame size to 320 x 240
module bayer_dither_rgb565_rotate_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bdr_pkg::PADDR_W-1:0] paddr,
  input  logic [bdr_pkg::APB_DW-1:0]  pwdata,
  output logic [bdr_pkg::APB_DW-1:0]  prdata,
  output logic                        pready,
  bdr_in_if.sink                      pix_in,
  bdr_out_if.source                   pix_out
);
  import bdr_pkg::*;

  cfg_t      cfg;
  pos_word_t word;
  logic      word_valid;
  logic      word_ready;

  bdr_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  bdr_position u_pos (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .pix_in     (pix_in),
    .word       (word),
    .word_valid (word_valid),
    .word_ready (word_ready)
  );

  bdr_convert u_conv (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .word       (word),
    .word_valid (word_valid),
    .word_ready (word_ready),
    .pix_out    (pix_out)
  );

endmodule
